// ===== sv/scba_pkg.sv =====
// Shared types, field widths, status codes and helper functions for the
// size-class block allocator. No dependencies.
package scba_pkg;

    // Fixed field widths
    localparam int CLASS_W     = 3;
    localparam int PAGE_W      = 4;
    localparam int BLOCK_W     = 8;
    localparam int OFFSET_W    = 16;
    localparam int STATUS_W    = 3;
    localparam int FCLASS_W    = 4;
    localparam int SIZE_W      = 32;

    // Free stack storage: eight class regions of 1024 entries each
    localparam int SLOT_W      = 10;
    localparam int DEPTH_W     = SLOT_W + 1;
    localparam int ADDR_W      = CLASS_W + SLOT_W;
    localparam int ENTRY_W     = PAGE_W + BLOCK_W;
    localparam int CLASS_SLOTS = 8;
    localparam int PAGE_LIMIT  = 16;
    localparam int PAGES_W     = PAGE_W + 1;

    // Result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t STATUS_ALLOCATED = 3'd0;
    localparam status_t STATUS_LARGE     = 3'd1;
    localparam status_t STATUS_NO_PAGES  = 3'd2;
    localparam status_t STATUS_FREED     = 3'd3;
    localparam status_t STATUS_IGNORED   = 3'd4;
    localparam status_t STATUS_OVERFLOW  = 3'd5;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Write port of the free stack memory
    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } ram_wr_t;

    // Index of the last block in a page of the given class (blocks per page minus one)
    function automatic logic [BLOCK_W-1:0] fill_last(input logic [CLASS_W-1:0] cls,
                                                     input int min_log,
                                                     input int page_log);
        int                 blog;
        logic [BLOCK_W-1:0] last;
        blog = min_log + int'(cls);
        if (blog >= page_log) begin
            last = '0;
        end else if (page_log - blog >= BLOCK_W) begin
            last = '1;
        end else begin
            last = BLOCK_W'((32'd1 << (page_log - blog)) - 32'd1);
        end
        return last;
    endfunction

    // Byte offset of a block within its page, low 16 bits
    function automatic logic [OFFSET_W-1:0] offset_of(input logic [CLASS_W-1:0] cls,
                                                      input logic [BLOCK_W-1:0] block,
                                                      input int min_log);
        logic [31:0] wide;
        wide = {24'd0, block} << (min_log + int'(cls));
        return wide[OFFSET_W-1:0];
    endfunction

endpackage

// ===== sv/size_class_block_allocator.sv =====
// Top level of the size-class block allocator: request sequencer, per-class
// depth and page counters, output register. Depends on scba_pkg, scba_stack_ram.
//
// Usage:
//   Slave channel (s_*) takes one request per transfer: s_tuser is the opcode
//   (0 allocate, 1 free), s_tdata carries size and the freed (class, page, block).
//   Master channel (m_*) returns exactly one result per request: m_tuser is the
//   status, m_tdata carries class, page, block, byte offset and page-opened flag.
//   One request is in flight at a time. A free, a large bypass or an out of
//   pages passes through decode, execute and done; a pop from a non-empty stack
//   adds a read state for the registered memory read data; when a new page is
//   opened, the fill state writes all blocks of the page but the last (up to 256
//   blocks per page) through the single write port of the free stack memory, one
//   per cycle, and hands out the last block directly.
//   The next request is accepted in the cycle after the result is loaded.
//   The result sits in an output register; a new request is accepted while it
//   waits, and the block holds its next result until m_tready drains the register.
//   Reset clears all stacks and page counters at once; no clearing pass is needed,
//   since only entries below a stack's depth are ever read.
module size_class_block_allocator #(
    parameter int MIN_BLOCK_LOG = 8,
    parameter int NUM_CLASSES   = 8,
    parameter int PAGE_LOG      = 16,
    parameter int MAX_PAGES     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] request_size, [35:32] free_class, [39:36] free_page, [47:40] free_block
    input  logic [47:0] s_tdata,
    // [0] opcode
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] size_class, [6:3] page_number, [14:7] block_number,
    // [30:15] byte_offset, [31] page_opened
    output logic [31:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser
);
    import scba_pkg::*;

    localparam int PAGE_CAP = (MAX_PAGES < PAGE_LIMIT) ? MAX_PAGES : PAGE_LIMIT;
    localparam logic [SIZE_W-1:0] MAX_SIZE = 32'd1 << (MIN_BLOCK_LOG + NUM_CLASSES - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_EXEC   = 6'b000100,
        S_FILL   = 6'b001000,
        S_READ   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    // Control state
    state_t              state_reg, state_next;
    logic [DEPTH_W-1:0]  depth_reg [CLASS_SLOTS];
    logic [DEPTH_W-1:0]  depth_next [CLASS_SLOTS];
    logic [PAGES_W-1:0]  pages_reg [CLASS_SLOTS];
    logic [PAGES_W-1:0]  pages_next [CLASS_SLOTS];
    logic                m_tvalid_reg, m_tvalid_next;

    // Request and result payload
    logic                op_reg, op_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [FCLASS_W-1:0] fcls_reg, fcls_next;
    logic [PAGE_W-1:0]   fpage_reg, fpage_next;
    logic [BLOCK_W-1:0]  fblock_reg, fblock_next;
    logic [CLASS_W-1:0]  cls_reg, cls_next;
    logic                large_reg, large_next;
    logic                ignore_reg, ignore_next;
    logic [BLOCK_W-1:0]  fill_cnt_reg, fill_cnt_next;
    logic [BLOCK_W-1:0]  fill_last_reg, fill_last_next;
    logic [PAGE_W-1:0]   fill_page_reg, fill_page_next;
    status_t             res_status_reg, res_status_next;
    logic [CLASS_W-1:0]  res_cls_reg, res_cls_next;
    logic [PAGE_W-1:0]   res_page_reg, res_page_next;
    logic [BLOCK_W-1:0]  res_block_reg, res_block_next;
    logic                res_opened_reg, res_opened_next;
    logic [31:0]         m_tdata_reg, m_tdata_next;
    logic [2:0]          m_tuser_reg, m_tuser_next;

    // Memory ports
    ram_wr_t             ram_wr;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [ENTRY_W-1:0]  ram_rd_data;

    logic [CLASS_W-1:0]  cls_calc;
    logic [DEPTH_W-1:0]  depth_cur;
    logic [PAGES_W-1:0]  pages_cur;

    scba_stack_ram u_stack_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign depth_cur = depth_reg[cls_reg];
    assign pages_cur = pages_reg[cls_reg];

    // Map request size to a class: count the class thresholds the size exceeds
    always_comb begin
        cls_calc = '0;
        for (int k = 1; k < NUM_CLASSES; k++) begin
            if (size_reg > (32'd1 << (MIN_BLOCK_LOG + k - 1))) begin
                cls_calc = cls_calc + 3'd1;
            end
        end
    end

    // Sequence one request through decode, stack access and result
    always_comb begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        pages_next      = pages_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        op_next         = op_reg;
        size_next       = size_reg;
        fcls_next       = fcls_reg;
        fpage_next      = fpage_reg;
        fblock_next     = fblock_reg;
        cls_next        = cls_reg;
        large_next      = large_reg;
        ignore_next     = ignore_reg;
        fill_cnt_next   = fill_cnt_reg;
        fill_last_next  = fill_last_reg;
        fill_page_next  = fill_page_reg;
        res_status_next = res_status_reg;
        res_cls_next    = res_cls_reg;
        res_page_next   = res_page_reg;
        res_block_next  = res_block_reg;
        res_opened_next = res_opened_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_wr          = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = {cls_reg, depth_cur[SLOT_W-1:0] - 10'd1};

        case (state_reg)
            S_IDLE: begin
                // Capture the request transfer
                if (s_tvalid) begin
                    op_next     = s_tuser[0];
                    size_next   = s_tdata[31:0];
                    fcls_next   = s_tdata[35:32];
                    fpage_next  = s_tdata[39:36];
                    fblock_next = s_tdata[47:40];
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (op_reg == OP_FREE) begin
                    cls_next    = fcls_reg[CLASS_W-1:0];
                    ignore_next = (fcls_reg >= FCLASS_W'(NUM_CLASSES));
                    large_next  = 1'b0;
                end else begin
                    cls_next    = cls_calc;
                    ignore_next = 1'b0;
                    large_next  = (size_reg > MAX_SIZE);
                end
                state_next = S_EXEC;
            end
            S_EXEC: begin
                res_status_next = STATUS_ALLOCATED;
                res_cls_next    = '0;
                res_page_next   = '0;
                res_block_next  = '0;
                res_opened_next = 1'b0;
                state_next      = S_DONE;
                if (op_reg == OP_FREE) begin
                    if (ignore_reg) begin
                        res_status_next = STATUS_IGNORED;
                    end else begin
                        // Push the pair unless the class stack is full
                        res_cls_next   = cls_reg;
                        res_page_next  = fpage_reg;
                        res_block_next = fblock_reg;
                        if (depth_cur[SLOT_W]) begin
                            res_status_next = STATUS_OVERFLOW;
                        end else begin
                            res_status_next     = STATUS_FREED;
                            ram_wr.en           = 1'b1;
                            ram_wr.addr         = {cls_reg, depth_cur[SLOT_W-1:0]};
                            ram_wr.data         = {fpage_reg, fblock_reg};
                            depth_next[cls_reg] = depth_cur + 11'd1;
                        end
                    end
                end else if (large_reg) begin
                    res_status_next = STATUS_LARGE;
                end else if (depth_cur == '0) begin
                    res_cls_next = cls_reg;
                    if (pages_cur >= PAGES_W'(PAGE_CAP)) begin
                        res_status_next = STATUS_NO_PAGES;
                    end else begin
                        // Open a new page and fill the stack with its blocks
                        pages_next[cls_reg] = pages_cur + 5'd1;
                        fill_page_next      = pages_cur[PAGE_W-1:0];
                        fill_cnt_next       = '0;
                        fill_last_next      = fill_last(cls_reg, MIN_BLOCK_LOG, PAGE_LOG);
                        state_next          = S_FILL;
                    end
                end else begin
                    // Pop the top entry
                    res_cls_next        = cls_reg;
                    ram_rd_en           = 1'b1;
                    depth_next[cls_reg] = depth_cur - 11'd1;
                    state_next          = S_READ;
                end
            end
            S_FILL: begin
                if (fill_cnt_reg == fill_last_reg) begin
                    // Last block is handed out directly; the rest stay stacked
                    depth_next[cls_reg] = DEPTH_W'(fill_last_reg);
                    res_status_next     = STATUS_ALLOCATED;
                    res_page_next       = fill_page_reg;
                    res_block_next      = fill_last_reg;
                    res_opened_next     = 1'b1;
                    state_next          = S_DONE;
                end else begin
                    ram_wr.en     = 1'b1;
                    ram_wr.addr   = {cls_reg, SLOT_W'(fill_cnt_reg)};
                    ram_wr.data   = {fill_page_reg, fill_cnt_reg};
                    fill_cnt_next = fill_cnt_reg + 8'd1;
                end
            end
            S_READ: begin
                res_status_next = STATUS_ALLOCATED;
                res_page_next   = ram_rd_data[ENTRY_W-1:BLOCK_W];
                res_block_next  = ram_rd_data[BLOCK_W-1:0];
                state_next      = S_DONE;
            end
            S_DONE: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_opened_reg,
                                     offset_of(res_cls_reg, res_block_reg, MIN_BLOCK_LOG),
                                     res_block_reg, res_page_reg, res_cls_reg};
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < CLASS_SLOTS; c++) begin
                depth_reg[c] <= '0;
                pages_reg[c] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            depth_reg    <= depth_next;
            pages_reg    <= pages_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        size_reg       <= size_next;
        fcls_reg       <= fcls_next;
        fpage_reg      <= fpage_next;
        fblock_reg     <= fblock_next;
        cls_reg        <= cls_next;
        large_reg      <= large_next;
        ignore_reg     <= ignore_next;
        fill_cnt_reg   <= fill_cnt_next;
        fill_last_reg  <= fill_last_next;
        fill_page_reg  <= fill_page_next;
        res_status_reg <= res_status_next;
        res_cls_reg    <= res_cls_next;
        res_page_reg   <= res_page_next;
        res_block_reg  <= res_block_next;
        res_opened_reg <= res_opened_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

// ===== sv/scba_stack_ram.sv =====
// Free stack memory: one write port, one read port with registered read data.
// Depends on scba_pkg.
module scba_stack_ram (
    input  logic                     aclk,
    input  scba_pkg::ram_wr_t        wr,
    input  logic                     rd_en,
    input  logic [scba_pkg::ADDR_W-1:0]  rd_addr,
    output logic [scba_pkg::ENTRY_W-1:0] rd_data
);
    import scba_pkg::*;

    logic [ENTRY_W-1:0] mem [1 << ADDR_W];
    logic [ENTRY_W-1:0] rd_data_reg;

    // Write and read in the same clocked block
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
